@@ rtl/core/tmia_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Time mark interval adjust: shared types, constants and arithmetic helpers
// Mode codes, register indexes, internal datapath width, rounding/saturation.
// ----------------------------------------------------------------------------
package tmia_pkg;

  // internal exact width; every intermediate stays well inside 36 bits
  localparam int unsigned PosW = 36;

  typedef enum logic [1:0] {
    MODE_CLIP   = 2'd0,
    MODE_DELETE = 2'd1,
    MODE_INSERT = 2'd2,
    MODE_SCALE  = 2'd3
  } mode_e;

  localparam logic [1:0] CFG_MODE  = 2'd0;
  localparam logic [1:0] CFG_ARG_A = 2'd1;
  localparam logic [1:0] CFG_ARG_B = 2'd2;
  localparam logic [1:0] CFG_SCALE = 2'd3;

  typedef logic signed [PosW-1:0] wide_t;

  localparam wide_t Int32Max = wide_t'(64'sh0000_0000_7FFF_FFFF);
  localparam wide_t Int32Min = -wide_t'(64'sh0000_0000_8000_0000);

  function automatic logic [31:0] sat32(input wide_t v);
    logic [31:0] r;
    if (v > Int32Max) begin
      r = 32'h7FFF_FFFF;
    end else if (v < Int32Min) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // round half away from zero of +/- prod / 2^16, saturated to 32 bits
  function automatic logic [31:0] round_sat(input logic neg, input logic [63:0] prod);
    logic [64:0] t;
    logic [48:0] r;
    logic [31:0] res;
    t = {1'b0, prod} + 65'h0_0000_0000_0000_8000;
    r = t[64:16];
    if (neg) begin
      if (r > 49'h0_8000_0000) begin
        res = 32'h8000_0000;
      end else begin
        res = 32'(-r);
      end
    end else begin
      if (r > 49'h0_7FFF_FFFF) begin
        res = 32'h7FFF_FFFF;
      end else begin
        res = r[31:0];
      end
    end
    return res;
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/time_mark_interval_adjust_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Time mark interval adjust core
// Clips, deletes from, inserts into or scales a stream of audio time marks.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: in_valid_i / in_stall_o, one mark per beat (position,
//   signed span, last flag). Output channel: out_valid_o / out_stall_i, one
//   result per mark (keep flag, new position, new span, last flag).
//   Configuration: cfg_valid_i / cfg_ready_o with cfg_index_i and cfg_data_i;
//   ready is always high. Write only while no mark is in flight.
//   One mark per cycle is sustained while out_stall_i is low, through the
//   three register stages (operand prep, mode compare/select and 32x32
//   scale multiplies, rounding/saturation).
//   Reset empties the pipeline and loads mode clip, arg_a = arg_b = 0 and a
//   scale factor of 1.0. A stall at the output holds the final beat; stages
//   behind it keep filling until full, then in_stall_o is raised.
// ----------------------------------------------------------------------------
module time_mark_interval_adjust_core (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic signed [31:0] mark_pos_i,
  input  wire logic signed [31:0] mark_span_i,
  input  wire logic               last_in_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic                    keep_o,
  output logic signed [31:0]      new_pos_o,
  output logic signed [31:0]      new_span_o,
  output logic                    last_out_o,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [1:0]         cfg_index_i,
  input  wire logic [31:0]        cfg_data_i
);

  // configuration
  tmia_pkg::mode_e mode_q;
  logic signed [31:0] arg_a_q, arg_b_q;
  logic [31:0] scale_q;
  tmia_pkg::wide_t cnt_q, lo_q, hi_q;
  logic signed [31:0] a_d, b_d;
  tmia_pkg::wide_t a_w, b_w;
  logic cfg_we;

  assign cfg_ready_o = 1'b1;
  assign cfg_we = cfg_valid_i && cfg_ready_o;

  always_comb begin
    a_d = arg_a_q;
    b_d = arg_b_q;
    if (cfg_we && cfg_index_i == tmia_pkg::CFG_ARG_A) begin
      a_d = cfg_data_i;
    end
    if (cfg_we && cfg_index_i == tmia_pkg::CFG_ARG_B) begin
      b_d = cfg_data_i;
    end
    a_w = tmia_pkg::wide_t'(a_d);
    b_w = tmia_pkg::wide_t'(b_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= tmia_pkg::MODE_CLIP;
      arg_a_q <= '0;
      arg_b_q <= '0;
      scale_q <= 32'h0001_0000;
      cnt_q   <= '0;
      lo_q    <= '0;
      hi_q    <= -tmia_pkg::wide_t'(1);
    end else if (cfg_we) begin
      unique case (cfg_index_i)
        tmia_pkg::CFG_MODE:  mode_q  <= tmia_pkg::mode_e'(cfg_data_i[1:0]);
        tmia_pkg::CFG_ARG_A: arg_a_q <= cfg_data_i;
        tmia_pkg::CFG_ARG_B: arg_b_q <= cfg_data_i;
        tmia_pkg::CFG_SCALE: scale_q <= cfg_data_i;
        default:             scale_q <= scale_q;
      endcase
      // removed / inserted run, kept in step with arg_a and arg_b
      if (b_w < 0) begin
        cnt_q <= -b_w;
        lo_q  <= a_w + b_w + tmia_pkg::wide_t'(1);
        hi_q  <= a_w;
      end else begin
        cnt_q <= b_w;
        lo_q  <= a_w;
        hi_q  <= a_w + b_w - tmia_pkg::wide_t'(1);
      end
    end
  end

  tmia_pkg::wide_t a_e, b_e;
  assign a_e = tmia_pkg::wide_t'(arg_a_q);
  assign b_e = tmia_pkg::wide_t'(arg_b_q);

  // handshake
  logic v1_q, v2_q, v3_q;
  logic rdy1, rdy2, rdy3;
  assign rdy3 = !v3_q || !out_stall_i;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign in_stall_o = !rdy1;

  // stage 1: operand preparation
  tmia_pkg::wide_t p_in, s_in, v_in;
  tmia_pkg::wide_t p1_q, s1_q, ep1_q, en1_q, ml1_q, mh1_q, as1_q;
  logic [31:0] vmag1_q, smag1_q;
  logic vneg1_q, last1_q;

  assign p_in = tmia_pkg::wide_t'(mark_pos_i);
  assign s_in = tmia_pkg::wide_t'(mark_span_i);
  assign v_in = p_in - a_e;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (rdy1) begin
      v1_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) begin
      p1_q    <= p_in;
      s1_q    <= s_in;
      ep1_q   <= p_in + s_in - tmia_pkg::wide_t'(1);
      en1_q   <= p_in + s_in + tmia_pkg::wide_t'(1);
      if (s_in < 0) begin
        ml1_q <= p_in + s_in + tmia_pkg::wide_t'(1);
        mh1_q <= p_in;
        as1_q <= -s_in;
      end else begin
        ml1_q <= p_in;
        mh1_q <= p_in + s_in - tmia_pkg::wide_t'(1);
        as1_q <= s_in;
      end
      vneg1_q <= v_in < 0;
      vmag1_q <= (v_in < 0) ? 32'(-v_in) : v_in[31:0];
      smag1_q <= (s_in < 0) ? 32'(-s_in) : s_in[31:0];
      last1_q <= last_in_i;
    end
  end

  // stage 2: mode decisions and scale products
  logic keep2_d;
  tmia_pkg::wide_t pos2_d, span2_d, m_mid, e_lim;
  logic keep2_q, last2_q, vneg2_q, sneg2_q;
  tmia_pkg::wide_t pos2_q, span2_q;
  logic [63:0] pprod2_q, sprod2_q;

  always_comb begin
    keep2_d = 1'b1;
    pos2_d  = p1_q;
    span2_d = s1_q;
    m_mid   = (hi_q > mh1_q) ? mh1_q : hi_q;
    e_lim   = '0;
    unique case (mode_q)
      tmia_pkg::MODE_CLIP: begin
        if (s1_q == 0) begin
          keep2_d = !(p1_q < a_e || p1_q > b_e);
        end else if (s1_q > 0) begin
          e_lim = (ep1_q > b_e) ? b_e : ep1_q;
          if (ep1_q < a_e || p1_q > b_e) begin
            keep2_d = 1'b0;
          end else if (p1_q < a_e) begin
            pos2_d  = a_e;
            span2_d = e_lim - a_e + tmia_pkg::wide_t'(1);
          end else if (ep1_q > b_e) begin
            span2_d = b_e - p1_q + tmia_pkg::wide_t'(1);
          end
        end else begin
          e_lim = (en1_q < a_e) ? a_e : en1_q;
          if (p1_q < a_e || en1_q > b_e) begin
            keep2_d = 1'b0;
          end else if (p1_q > b_e) begin
            pos2_d  = b_e;
            span2_d = e_lim - b_e - tmia_pkg::wide_t'(1);
          end else if (en1_q < a_e) begin
            span2_d = a_e - p1_q - tmia_pkg::wide_t'(1);
          end
        end
      end
      tmia_pkg::MODE_DELETE: begin
        if (cnt_q == 0) begin
          keep2_d = 1'b1;
        end else if (s1_q == 0) begin
          if (p1_q >= lo_q) begin
            if (p1_q <= hi_q) begin
              keep2_d = 1'b0;
            end else begin
              pos2_d = p1_q - cnt_q;
            end
          end
        end else if (lo_q < ml1_q) begin
          if (hi_q >= mh1_q) begin
            keep2_d = 1'b0;
          end else if (hi_q < ml1_q) begin
            pos2_d = p1_q - cnt_q;
          end else if (s1_q > 0) begin
            span2_d = as1_q + ml1_q - hi_q - tmia_pkg::wide_t'(1);
            pos2_d  = lo_q;
          end else begin
            span2_d = s1_q - ml1_q + hi_q + tmia_pkg::wide_t'(1);
            pos2_d  = p1_q - cnt_q;
          end
        end else if (lo_q <= mh1_q) begin
          if (as1_q - m_mid + lo_q - tmia_pkg::wide_t'(1) == 0) begin
            keep2_d = 1'b0;
          end else if (s1_q > 0) begin
            span2_d = as1_q - m_mid + lo_q - tmia_pkg::wide_t'(1);
          end else begin
            span2_d = s1_q + m_mid - lo_q + tmia_pkg::wide_t'(1);
            pos2_d  = p1_q - m_mid + lo_q - tmia_pkg::wide_t'(1);
          end
        end
      end
      tmia_pkg::MODE_INSERT: begin
        if (cnt_q == 0) begin
          keep2_d = 1'b1;
        end else if (s1_q == 0) begin
          if (p1_q >= a_e) begin
            pos2_d = p1_q + cnt_q;
          end
        end else if (s1_q > 0) begin
          if (a_e <= p1_q) begin
            pos2_d = p1_q + cnt_q;
          end else if (a_e < ep1_q) begin
            span2_d = s1_q + cnt_q;
          end
        end else begin
          if (a_e <= en1_q) begin
            pos2_d = p1_q + cnt_q;
          end else if (a_e < p1_q) begin
            span2_d = s1_q - cnt_q;
          end
        end
      end
      tmia_pkg::MODE_SCALE: begin
        keep2_d = 1'b1;
      end
      default: keep2_d = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (rdy2) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy2 && v1_q) begin
      keep2_q  <= keep2_d;
      pos2_q   <= pos2_d;
      span2_q  <= span2_d;
      pprod2_q <= 64'(vmag1_q) * 64'(scale_q);
      sprod2_q <= 64'(smag1_q) * 64'(scale_q);
      vneg2_q  <= vneg1_q;
      sneg2_q  <= s1_q < 0;
      last2_q  <= last1_q;
    end
  end

  // stage 3: rounding, saturation, output beat
  logic [31:0] pos3_d, span3_d;
  logic keep3_q, last3_q;
  logic [31:0] pos3_q, span3_q;

  always_comb begin
    if (mode_q == tmia_pkg::MODE_SCALE) begin
      pos3_d  = tmia_pkg::round_sat(vneg2_q, pprod2_q);
      span3_d = tmia_pkg::round_sat(sneg2_q, sprod2_q);
    end else begin
      pos3_d  = tmia_pkg::sat32(pos2_q);
      span3_d = tmia_pkg::sat32(span2_q);
    end
    if (!keep2_q) begin
      pos3_d  = '0;
      span3_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (rdy3) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy3 && v2_q) begin
      keep3_q <= keep2_q;
      pos3_q  <= pos3_d;
      span3_q <= span3_d;
      last3_q <= last2_q;
    end
  end

  assign out_valid_o = v3_q;
  assign keep_o      = keep3_q;
  assign new_pos_o   = pos3_q;
  assign new_span_o  = span3_q;
  assign last_out_o  = last3_q;

endmodule
`default_nettype wire
